// ===== hdl/rcnh_pkg.sv =====
package rcnh_pkg;

   localparam int COORD_W = 24;
   localparam int DIFF_W  = 25;
   localparam int DIR_W   = 16;
   localparam int PROJ_W  = 42;
   localparam int P_W     = 27;
   localparam int D2_W    = 50;
   localparam int P2_W    = 54;
   localparam int R2_W    = 34;
   localparam int RAD_W   = 56;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int T_W     = 29;
   localparam int DIST_W  = 19;
   localparam int RADIUS_W = 16;
   localparam int IDX_OUT_W = 4;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd1835;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic vld;
      logic last;
      logic cand;
   } tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/ray_circle_nearest_hit.sv =====
// Writes return nothing; a query returns one response.
// A query issues one table entry per cycle from a single-port table read, then each
// entry passes a 6-stage geometry pipeline and a 28-stage square root pipeline.
// One query is in flight at a time.
// Synchronous reset clears the active flags and sets the radius to 1835; the
// centre table is not cleared.
module ray_circle_nearest_hit #(
   parameter int NUM_ENTRIES  = 16,
   parameter int MIN_HIT_DIST = 7
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // entry_index, point_x, point_y, entry_active, dir_x, dir_y, max_dist
   input  logic [103:0] req_tdata,
   // op
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit_index, hit_distance, zero padding
   output logic [23:0]  rsp_tdata,
   // hit
   output logic [0:0]   rsp_tuser
);
   import rcnh_pkg::*;

   localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);

   logic [3:0]              f_idx;
   logic [COORD_W-1:0]      f_px, f_py;
   logic                    f_act;
   logic [DIR_W-1:0]        f_dx, f_dy;
   logic [DIST_W-1:0]       f_max;
   logic                    req_acc;

   assign f_idx = req_tdata[3:0];
   assign f_px  = req_tdata[27:4];
   assign f_py  = req_tdata[51:28];
   assign f_act = req_tdata[52];
   assign f_dx  = req_tdata[68:53];
   assign f_dy  = req_tdata[84:69];
   assign f_max = req_tdata[103:85];

   state_type state_ff, state_in;
   logic [RADIUS_W-1:0] radius_ff;
   logic [R2_W-1:0] r2_ff;
   logic [RADIUS_W:0] diam;
   logic [COORD_W-1:0] org_x_ff, org_y_ff;
   logic [DIR_W-1:0] dir_x_ff, dir_y_ff;
   logic [IW-1:0] cnt_ff;
   logic [DIST_W-1:0] best_ff;
   logic [IW-1:0] best_idx_ff;
   logic found_ff;
   logic rsp_vld_ff;
   logic rsp_hit_ff;
   logic [IDX_OUT_W-1:0] rsp_idx_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   logic issue, issue_last, start, load_rsp, wr_en;

   assign diam    = {radius_ff, 1'b0};
   assign req_acc = req_tvalid & req_tready;
   assign start   = req_acc & (req_tuser[0] == OP_QUERY);
   assign wr_en   = req_acc & (req_tuser[0] == OP_WRITE) & (int'(f_idx) < NUM_ENTRIES);
   assign issue_last = cnt_ff == LAST_IDX;

   logic [COORD_W-1:0] t_x, t_y;
   logic [IW-1:0] t_idx, g_idx, s_idx;
   tag_type t_tag, g_tag, s_tag;
   logic [RAD_W-1:0] g_rad;
   logic [P_W-1:0] g_p, s_p;
   logic [ROOT_W-1:0] s_root;

   rcnh_table #(.NUM_ENTRIES(NUM_ENTRIES), .IW(IW)) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (IW'(f_idx)),
      .wr_x    (f_px),
      .wr_y    (f_py),
      .wr_act  (f_act),
      .rd_en   (issue),
      .rd_last (issue_last),
      .rd_addr (cnt_ff),
      .rd_x    (t_x),
      .rd_y    (t_y),
      .rd_idx  (t_idx),
      .rd_tag  (t_tag)
   );

   rcnh_geom #(.IW(IW)) u_geom (
      .clock   (clock),
      .reset   (reset),
      .org_x   ($signed(org_x_ff)),
      .org_y   ($signed(org_y_ff)),
      .dir_x   ($signed(dir_x_ff)),
      .dir_y   ($signed(dir_y_ff)),
      .r2      (r2_ff),
      .cen_x   (t_x),
      .cen_y   (t_y),
      .in_idx  (t_idx),
      .in_tag  (t_tag),
      .rad     (g_rad),
      .proj    (g_p),
      .out_idx (g_idx),
      .out_tag (g_tag)
   );

   rcnh_sqrt #(.IW(IW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .rad      (g_rad),
      .in_proj  (g_p),
      .in_idx   (g_idx),
      .in_tag   (g_tag),
      .root     (s_root),
      .out_proj (s_p),
      .out_idx  (s_idx),
      .out_tag  (s_tag)
   );

   logic signed [T_W-1:0] t_dist;
   logic take;

   assign t_dist = $signed({2'b00, s_p}) - $signed({1'b0, s_root});
   assign take   = s_tag.vld & s_tag.cand & (t_dist > $signed(T_W'(MIN_HIT_DIST)))
                 & (t_dist < $signed({{(T_W-DIST_W){1'b0}}, best_ff}));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s_tag.vld && s_tag.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_ISSUE: issue = 1'b1;
         ST_DRAIN: issue = 1'b0;
         ST_DONE:  load_rsp = !rsp_vld_ff || rsp_tready;
         default:  req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         radius_ff  <= RADIUS_RESET;
         rsp_vld_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
         if (start) begin
            cnt_ff <= IW'(1);
         end else if (issue) begin
            cnt_ff <= cnt_ff + IW'(1);
         end
         if (load_rsp) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      r2_ff <= diam * diam;
      if (start) begin
         org_x_ff    <= f_px;
         org_y_ff    <= f_py;
         dir_x_ff    <= f_dx;
         dir_y_ff    <= f_dy;
         best_ff     <= f_max;
         best_idx_ff <= '0;
         found_ff    <= 1'b0;
      end else if (take) begin
         best_ff     <= t_dist[DIST_W-1:0];
         best_idx_ff <= s_idx;
         found_ff    <= 1'b1;
      end
      if (load_rsp) begin
         rsp_hit_ff  <= found_ff;
         rsp_idx_ff  <= IDX_OUT_W'(best_idx_ff);
         rsp_dist_ff <= best_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_dist_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_hit_ff;

endmodule

// ===== hdl/rcnh_table.sv =====
module rcnh_table #(
   parameter int NUM_ENTRIES = 16,
   parameter int IW = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [IW-1:0]                 wr_addr,
   input  logic [rcnh_pkg::COORD_W-1:0]  wr_x,
   input  logic [rcnh_pkg::COORD_W-1:0]  wr_y,
   input  logic                          wr_act,
   input  logic                          rd_en,
   input  logic                          rd_last,
   input  logic [IW-1:0]                 rd_addr,
   output logic [rcnh_pkg::COORD_W-1:0]  rd_x,
   output logic [rcnh_pkg::COORD_W-1:0]  rd_y,
   output logic [IW-1:0]                 rd_idx,
   output rcnh_pkg::tag_type             rd_tag
);
   import rcnh_pkg::*;

   logic [2*COORD_W-1:0] mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] act_ff;
   logic [2*COORD_W-1:0] rd_data_ff;
   logic [IW-1:0] idx_ff;
   tag_type tag_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_y, wr_x};
      end
      rd_data_ff <= mem[rd_addr];
      idx_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
         tag_ff <= '0;
      end else begin
         if (wr_en) begin
            act_ff[wr_addr] <= wr_act;
         end
         tag_ff.vld  <= rd_en;
         tag_ff.last <= rd_last;
         tag_ff.cand <= rd_en & act_ff[rd_addr];
      end
   end

   assign rd_x   = rd_data_ff[COORD_W-1:0];
   assign rd_y   = rd_data_ff[2*COORD_W-1:COORD_W];
   assign rd_idx = idx_ff;
   assign rd_tag = tag_ff;

endmodule

// ===== hdl/rcnh_geom.sv =====
module rcnh_geom #(
   parameter int IW = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [rcnh_pkg::COORD_W-1:0] org_x,
   input  logic signed [rcnh_pkg::COORD_W-1:0] org_y,
   input  logic signed [rcnh_pkg::DIR_W-1:0]   dir_x,
   input  logic signed [rcnh_pkg::DIR_W-1:0]   dir_y,
   input  logic [rcnh_pkg::R2_W-1:0]           r2,
   input  logic [rcnh_pkg::COORD_W-1:0]        cen_x,
   input  logic [rcnh_pkg::COORD_W-1:0]        cen_y,
   input  logic [IW-1:0]                       in_idx,
   input  rcnh_pkg::tag_type                   in_tag,
   output logic [rcnh_pkg::RAD_W-1:0]          rad,
   output logic [rcnh_pkg::P_W-1:0]            proj,
   output logic [IW-1:0]                       out_idx,
   output rcnh_pkg::tag_type                   out_tag
);
   import rcnh_pkg::*;

   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic signed [DIFF_W+DIR_W-1:0] mx_ff, my_ff;
   logic [2*DIFF_W-2:0] sx_ff, sy_ff;
   logic signed [PROJ_W-1:0] p30_ff;
   logic [D2_W-1:0] d2_ff, d2b_ff, d2c_ff;
   logic [P_W-1:0] p_ff, pe_ff, pf_ff;
   logic [P2_W-1:0] p2_ff;
   logic [RAD_W-1:0] rad_ff;
   logic [IW-1:0] ia_ff, ib_ff, ic_ff, id_ff, ie_ff, if_ff;
   tag_type ta_ff, tb_ff, tc_ff, td_ff, te_ff, tf_ff;

   logic signed [2*DIFF_W-1:0] sqx, sqy;
   logic signed [RAD_W:0] c2;
   logic signed [RAD_W:0] r2s;

   assign sqx = dx_ff * dx_ff;
   assign sqy = dy_ff * dy_ff;
   assign c2  = $signed({7'd0, d2c_ff}) - $signed({3'd0, p2_ff});
   assign r2s = $signed({23'd0, r2});

   always_ff @(posedge clock) begin
      dx_ff  <= $signed({cen_x[COORD_W-1], cen_x}) - $signed({org_x[COORD_W-1], org_x});
      dy_ff  <= $signed({cen_y[COORD_W-1], cen_y}) - $signed({org_y[COORD_W-1], org_y});
      ia_ff  <= in_idx;
      mx_ff  <= dx_ff * dir_x;
      my_ff  <= dy_ff * dir_y;
      sx_ff  <= sqx[2*DIFF_W-2:0];
      sy_ff  <= sqy[2*DIFF_W-2:0];
      ib_ff  <= ia_ff;
      p30_ff <= PROJ_W'(mx_ff) + PROJ_W'(my_ff);
      d2_ff  <= D2_W'(sx_ff) + D2_W'(sy_ff);
      ic_ff  <= ib_ff;
      p_ff   <= p30_ff[P_W+13:14];
      d2b_ff <= d2_ff;
      id_ff  <= ic_ff;
      p2_ff  <= p_ff * p_ff;
      pe_ff  <= p_ff;
      d2c_ff <= d2b_ff;
      ie_ff  <= id_ff;
      rad_ff <= RAD_W'(r2s - c2);
      pf_ff  <= pe_ff;
      if_ff  <= ie_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ta_ff <= '0;
         tb_ff <= '0;
         tc_ff <= '0;
         td_ff <= '0;
         te_ff <= '0;
         tf_ff <= '0;
      end else begin
         ta_ff <= in_tag;
         tb_ff <= ta_ff;
         tc_ff <= tb_ff;
         td_ff <= '{vld: tc_ff.vld, last: tc_ff.last, cand: tc_ff.cand & (p30_ff > 0)};
         te_ff <= td_ff;
         tf_ff <= '{vld: te_ff.vld, last: te_ff.last, cand: te_ff.cand & (c2 <= r2s)};
      end
   end

   assign rad     = rad_ff;
   assign proj    = pf_ff;
   assign out_idx = if_ff;
   assign out_tag = tf_ff;

endmodule

// ===== hdl/rcnh_sqrt.sv =====
module rcnh_sqrt #(
   parameter int IW = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rcnh_pkg::RAD_W-1:0]  rad,
   input  logic [rcnh_pkg::P_W-1:0]    in_proj,
   input  logic [IW-1:0]               in_idx,
   input  rcnh_pkg::tag_type           in_tag,
   output logic [rcnh_pkg::ROOT_W-1:0] root,
   output logic [rcnh_pkg::P_W-1:0]    out_proj,
   output logic [IW-1:0]               out_idx,
   output rcnh_pkg::tag_type           out_tag
);
   import rcnh_pkg::*;

   logic [RAD_W-1:0]  v_ff    [ROOT_W+1];
   logic [REM_W-1:0]  rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff [ROOT_W+1];
   logic [P_W-1:0]    p_ff    [ROOT_W+1];
   logic [IW-1:0]     idx_ff  [ROOT_W+1];
   tag_type           tag_ff  [ROOT_W+1];

   always_comb begin
      v_ff[0]    = rad;
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      p_ff[0]    = in_proj;
      idx_ff[0]  = in_idx;
      tag_ff[0]  = in_tag;
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic take;

      assign rem_sh = {rem_ff[k][REM_W-3:0], v_ff[k][RAD_W-1:RAD_W-2]};
      assign trial  = {root_ff[k], 2'b01};
      assign take   = rem_sh >= trial;

      always_ff @(posedge clock) begin
         v_ff[k+1]    <= {v_ff[k][RAD_W-3:0], 2'b00};
         rem_ff[k+1]  <= take ? rem_sh - trial : rem_sh;
         root_ff[k+1] <= {root_ff[k][ROOT_W-2:0], take};
         p_ff[k+1]    <= p_ff[k];
         idx_ff[k+1]  <= idx_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k+1] <= '0;
         end else begin
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   assign root     = root_ff[ROOT_W];
   assign out_proj = p_ff[ROOT_W];
   assign out_idx  = idx_ff[ROOT_W];
   assign out_tag  = tag_ff[ROOT_W];

endmodule

// ===== bench/tb_ray_circle_nearest_hit.sv =====
module tb_ray_circle_nearest_hit;
   import rcnh_pkg::*;

   localparam int NUM_ENTRIES  = 16;
   localparam int MIN_HIT_DIST = 7;
   localparam int DRAIN_CYCLES = NUM_ENTRIES + 60;

   typedef struct {
      logic        op;
      logic [3:0]  entry_index;
      logic [23:0] point_x;
      logic [23:0] point_y;
      logic        entry_active;
      logic [15:0] dir_x;
      logic [15:0] dir_y;
      logic [18:0] max_dist;
   } request_type;

   typedef struct {
      logic        hit;
      logic [3:0]  hit_index;
      logic [18:0] hit_distance;
   } hit_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   logic [15:0]   csr_wr_data = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [103:0]  req_tdata = '0;
   logic [0:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [23:0]   rsp_tdata;
   logic [0:0]    rsp_tuser;

   request_type   pending_requests[$];
   hit_type       expected_hits[$];
   request_type   current_request;
   int            error_count = 0;
   int            sent_count = 0;
   int            received_count = 0;
   int            send_gap = 0;
   int            recv_gap = 0;
   bit            wait_for_drain = 1'b0;

   // Predictor state.
   logic [23:0]   table_x[NUM_ENTRIES];
   logic [23:0]   table_y[NUM_ENTRIES];
   logic          table_active[NUM_ENTRIES];
   logic [15:0]   radius_q16;

   // Generator shadow of the table, used only to aim rays.
   longint        aim_x[NUM_ENTRIES];
   longint        aim_y[NUM_ENTRIES];
   bit            aim_active[NUM_ENTRIES];

   ray_circle_nearest_hit #(
      .NUM_ENTRIES(NUM_ENTRIES),
      .MIN_HIT_DIST(MIN_HIT_DIST)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic hit_type nearest_hit(request_type rq);
      hit_type        res;
      longint         best, diam, r2, ddx, ddy, p30, p, c2, off, t;
      longint         ox, oy, vx, vy;
      res.hit = 1'b0;
      res.hit_index = '0;
      ox = longint'(signed'(rq.point_x));
      oy = longint'(signed'(rq.point_y));
      vx = longint'(signed'(rq.dir_x));
      vy = longint'(signed'(rq.dir_y));
      best = longint'(rq.max_dist);
      diam = 2 * longint'(radius_q16);
      r2 = diam * diam;
      for (int i = 1; i < NUM_ENTRIES; i++) begin
         if (!table_active[i]) continue;
         ddx = longint'(signed'(table_x[i])) - ox;
         ddy = longint'(signed'(table_y[i])) - oy;
         p30 = ddx * vx + ddy * vy;
         if (p30 <= 0) continue;
         p = p30 >>> 14;
         c2 = ddx * ddx + ddy * ddy - p * p;
         if (c2 > r2) continue;
         off = longint'(int_sqrt(longint'(r2 - c2)));
         t = p - off;
         if (t <= MIN_HIT_DIST) continue;
         if (t < best) begin
            best = t;
            res.hit = 1'b1;
            res.hit_index = 4'(i);
         end
      end
      res.hit_distance = 19'(best);
      return res;
   endfunction

   function automatic logic [103:0] pack_request(request_type rq);
      return {rq.max_dist, rq.dir_y, rq.dir_x, rq.entry_active,
              rq.point_y, rq.point_x, rq.entry_index};
   endfunction

   function automatic int draw_gap(int count);
      if ((count / 64) % 3 == 0) return 0;
      return $urandom_range(0, 9);
   endfunction

   task automatic apply_request(request_type rq);
      if (rq.op == OP_WRITE) begin
         table_x[rq.entry_index] = rq.point_x;
         table_y[rq.entry_index] = rq.point_y;
         table_active[rq.entry_index] = rq.entry_active;
      end else begin
         expected_hits.push_back(nearest_hit(rq));
      end
   endtask

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         radius_q16 = RADIUS_RESET;
         for (int i = 0; i < NUM_ENTRIES; i++) table_active[i] = 1'b0;
      end else begin
         if (csr_wr_en) radius_q16 = csr_wr_data;
         if (req_tvalid && req_tready) begin
            apply_request(current_request);
            sent_count++;
            send_gap = draw_gap(sent_count);
            if (sent_count == 700) wait_for_drain = 1'b1;
         end
         if (wait_for_drain && expected_hits.size() == 0 && !(req_tvalid && !req_tready))
            wait_for_drain = 1'b0;
         if (req_tvalid && !req_tready) begin
            // Hold the current request.
         end else if (send_gap == 0 && !wait_for_drain && pending_requests.size() > 0) begin
            current_request = pending_requests.pop_front();
            req_tdata <= pack_request(current_request);
            req_tuser <= current_request.op;
            req_tvalid <= 1'b1;
         end else begin
            if (send_gap > 0) send_gap--;
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      hit_type exp_hit;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            received_count++;
            if (expected_hits.size() == 0) begin
               $error("unexpected response hit=%0d index=%0d distance=%0d",
                      rsp_tuser[0], rsp_tdata[3:0], rsp_tdata[22:4]);
               error_count++;
            end else begin
               exp_hit = expected_hits.pop_front();
               if (rsp_tuser[0] !== exp_hit.hit) begin
                  $error("hit expected %0d actual %0d", exp_hit.hit, rsp_tuser[0]);
                  error_count++;
               end
               if (rsp_tdata[3:0] !== exp_hit.hit_index) begin
                  $error("hit_index expected %0d actual %0d",
                         exp_hit.hit_index, rsp_tdata[3:0]);
                  error_count++;
               end
               if (rsp_tdata[22:4] !== exp_hit.hit_distance) begin
                  $error("hit_distance expected %0d actual %0d",
                         exp_hit.hit_distance, rsp_tdata[22:4]);
                  error_count++;
               end
            end
            recv_gap = (received_count == 150) ? 600 : draw_gap(received_count);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_write(int idx, longint x, longint y, bit act);
      request_type rq;
      rq = '{OP_WRITE, 4'(idx), 24'(x), 24'(y), act,
             16'($urandom), 16'($urandom), 19'($urandom)};
      pending_requests.push_back(rq);
      aim_x[idx] = longint'(signed'(24'(x)));
      aim_y[idx] = longint'(signed'(24'(y)));
      aim_active[idx] = act;
   endtask

   task automatic push_query(longint x, longint y, longint vx, longint vy, longint md);
      request_type rq;
      rq = '{OP_QUERY, 4'($urandom), 24'(x), 24'(y), 1'($urandom),
             16'(vx), 16'(vy), 19'(md)};
      pending_requests.push_back(rq);
   endtask

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic push_aimed_query();
      int     k;
      longint ox, oy, vx, vy, md;
      real    ux, uy, len, ang;
      k = $urandom_range(1, NUM_ENTRIES - 1);
      ox = clamp(aim_x[k] + $signed($urandom_range(0, 262144)) - 131072,
                 -8388608, 8388607);
      oy = clamp(aim_y[k] + $signed($urandom_range(0, 262144)) - 131072,
                 -8388608, 8388607);
      ux = real'(aim_x[k] - ox);
      uy = real'(aim_y[k] - oy);
      len = $sqrt(ux * ux + uy * uy);
      if (len < 1.0 || $urandom_range(0, 4) == 0) begin
         ang = real'($urandom_range(0, 62831)) / 10000.0;
         ux = $cos(ang);
         uy = $sin(ang);
         len = 1.0;
      end
      vx = clamp(longint'($rtoi(ux / len * 16384.0)) + $urandom_range(0, 400) - 200,
                 -16384, 16384);
      vy = clamp(longint'($rtoi(uy / len * 16384.0)) + $urandom_range(0, 400) - 200,
                 -16384, 16384);
      if ($urandom_range(0, 9) < 7) md = 524287 - $urandom_range(0, 1000);
      else md = $urandom_range(0, 524287);
      push_query(ox, oy, vx, vy, md);
   endtask

   task automatic push_random_item();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         push_write($urandom_range(0, 15), $signed($urandom_range(0, 1048576)) - 524288,
                    $signed($urandom_range(0, 1048576)) - 524288, $urandom_range(0, 5) != 0);
      end else if (sel < 90) begin
         push_aimed_query();
      end else if (sel < 95) begin
         push_write($urandom_range(0, 15), $signed(24'($urandom)), $signed(24'($urandom)),
                    $urandom_range(0, 1));
      end else begin
         push_query($signed(24'($urandom)), $signed(24'($urandom)),
                    $signed(16'($urandom)), $signed(16'($urandom)), 19'($urandom));
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_hits.size() != 0
             || wait_for_drain);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_radius(logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [15:0] radii[5];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests at the reset radius.
      push_query(0, 0, 16384, 0, 524287);
      push_write(0, 0, 0, 1'b1);
      push_write(1, 65536, 0, 1'b1);
      push_write(2, 131072, 0, 1'b1);
      push_write(3, 131072, 0, 1'b1);
      push_write(4, -8388608, 8388607, 1'b1);
      push_write(5, 8388607, -8388608, 1'b0);
      push_write(15, 0, 3000, 1'b1);
      push_query(0, 0, 16384, 0, 524287);
      push_query(0, 0, -16384, 0, 524287);
      push_query(0, 0, 16384, 0, 0);
      push_query(0, 0, 16384, 0, 65536);
      push_query(98304, 0, 16384, 0, 524287);
      push_query(0, 0, 0, 16384, 524287);
      push_query(8388607, -8388608, -16384, 16384, 524287);
      push_query(-8388608, 8388607, 16384, -16384, 524287);
      push_query(0, 0, -32768, 32767, 524287);
      push_query(0, 0, 32767, -32768, 524287);
      push_write(1, 65536, 0, 1'b0);
      push_query(0, 0, 16384, 0, 524287);
      wait_idle();

      radii = '{16'd0, 16'd65535, 16'd1835, 16'($urandom_range(1, 20000)), 16'd4000};
      for (int ph = 0; ph < 5; ph++) begin
         write_radius(radii[ph]);
         for (int i = 1; i < NUM_ENTRIES; i++)
            push_write(i, $signed($urandom_range(0, 1048576)) - 524288,
                       $signed($urandom_range(0, 1048576)) - 524288, $urandom_range(0, 3) != 0);
         for (int n = 0; n < 270; n++) push_random_item();
         wait_idle();
      end

      if (error_count == 0 && expected_hits.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (expected_hits.size() != 0)
            $error("%0d expected responses never arrived", expected_hits.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #(10 * 900000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rcnh_pkg.sv
hdl/rcnh_table.sv
hdl/rcnh_geom.sv
hdl/rcnh_sqrt.sv
hdl/ray_circle_nearest_hit.sv
bench/tb_ray_circle_nearest_hit.sv
